### sv/ktt_pkg.sv
// Shared constants and types for the keyed timer table.
package ktt_pkg;
    localparam int SLOTS_DEF = 32;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_DEL    = 3'd1;
    localparam logic [2:0] KIND_DELALL = 3'd2;
    localparam logic [2:0] KIND_POLL   = 3'd3;
    localparam logic [2:0] KIND_EXISTS = 3'd4;
    localparam logic [2:0] KIND_FLUSH  = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_MISS    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_FIRED   = 3'd4;
    localparam logic [2:0] ST_POLLEND = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [15:0] owner;
        logic [16:0] key;
        logic [32:0] expiry;
        logic [15:0] action;
        logic [31:0] payload;
    } entry_t;

    // Per-cycle command seen by every cell.
    typedef struct packed {
        logic        rotate;   // take the entry from the head-side neighbor
        logic        insert;   // shift toward the head up to the first hole
    } cell_ctl_t;
endpackage

### sv/ktt_cell.sv
// One timer cell: holds one entry and passes it to a neighbor on rotate or insert.
module ktt_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  ktt_pkg::cell_ctl_t ctl,
    input  ktt_pkg::entry_t    prev,
    input  ktt_pkg::entry_t    nxt,
    input  logic               hole_in,
    output logic               hole_out,
    output ktt_pkg::entry_t    cur
);
    ktt_pkg::entry_t ent_reg;
    ktt_pkg::entry_t ent_next;

    // hole_out: some cell at or below this one is empty
    assign hole_out = hole_in || !ent_reg.valid;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.insert)
        begin
            if (hole_out)
                ent_next = nxt;
        end
        else if (ctl.rotate)
            ent_next = prev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_reg <= '0;
        else
            ent_reg <= ent_next;
    end

    assign cur = ent_reg;
endmodule

### sv/keyed_timer_table.sv
// Top level of the keyed timer table: command sequencer around a row of timer cells.
//
// Usage: drive kind and its operands and raise start while busy is low; the
// item is taken on that edge. Results come back on status/out_* with strobe
// high for exactly one cycle each; last marks the final result of the item.
// The receiver cannot stall the block, so results are never held.
//
// The timers live in a row of SLOTS cells. Reading from the tail (cell
// SLOTS-1) toward the head (cell 0), valid entries are newest to oldest;
// empty cells may sit anywhere. Every item makes one full rotation of the
// row, looking at the tail entry each cycle and feeding it back to the head, or
// dropping it. So entries are visited newest first, and poll fires its results
// during the rotation, one per cycle at most.
// Add has one more step, S_INS: if the key is new and an empty cell exists, the
// cells from the lowest hole up to the tail shift one toward the head and the
// new timer lands at the tail as the newest.
// A new item is taken only in idle, after the final result of the last one,
// when busy is low again.
// Reset clears all valid bits and the generated key counter at once.
module keyed_timer_table
#(
    parameter int SLOTS = ktt_pkg::SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [15:0] owner,
    input  logic [15:0] timer_key,
    input  logic        auto_key,
    input  logic [31:0] interval,
    input  logic [31:0] now,
    input  logic [15:0] action,
    input  logic [31:0] payload,
    output logic        strobe,
    output logic [2:0]  status,
    output logic [15:0] out_key,
    output logic        out_auto,
    output logic [15:0] out_owner,
    output logic [15:0] out_action,
    output logic [31:0] out_payload,
    output logic [5:0]  removed_count,
    output logic        timers_left,
    output logic        last
);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    kind_reg;
    logic [15:0]   own_reg;
    logic [16:0]   key_reg;
    logic [32:0]   exp_reg;
    logic [15:0]   act_reg;
    logic [31:0]   pay_reg;
    logic [32:0]   now_reg;
    logic [15:0]   gen_reg, gen_next;
    logic          hit_reg, hit_next;
    logic          left_reg, left_next;
    logic          full_reg, full_next;
    logic [5:0]    rem_reg, rem_next;

    ktt_pkg::cell_ctl_t ctl;
    ktt_pkg::entry_t    cell_out [SLOTS];
    logic               hole [SLOTS];
    ktt_pkg::entry_t    head_in;
    ktt_pkg::entry_t    tail;
    ktt_pkg::entry_t    new_ent;

    logic          match;
    logic          expired;
    logic          drop_now;
    logic          do_ins;

    // Row wraps as a ring: tail feeds head.
    assign tail = cell_out[SLOTS-1];

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            ktt_pkg::entry_t prev_ent;
            ktt_pkg::entry_t nxt_ent;
            logic            hole_below;
            if (g == 0)
            begin : g_head
                assign prev_ent   = head_in;
                assign hole_below = 1'b0;
            end
            else
            begin : g_body
                assign prev_ent   = cell_out[g-1];
                assign hole_below = hole[g-1];
            end
            // The tail takes the new timer on insert.
            if (g == SLOTS - 1)
            begin : g_tail
                assign nxt_ent = new_ent;
            end
            else
            begin : g_inner
                assign nxt_ent = cell_out[g+1];
            end
            ktt_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl),
                             .prev(prev_ent), .nxt(nxt_ent),
                             .hole_in(hole_below), .hole_out(hole[g]),
                             .cur(cell_out[g]));
        end
    endgenerate

    assign match   = tail.valid && tail.owner == own_reg && tail.key == key_reg;
    assign expired = tail.expiry <= now_reg;

    // hole[SLOTS-1]: at least one empty cell in the row
    assign do_ins = (state_reg == S_INS) && !hit_reg && hole[SLOTS-1];

    always_comb
    begin
        new_ent.valid   = 1'b1;
        new_ent.owner   = own_reg;
        new_ent.key     = key_reg[16] ? {1'b1, gen_reg} : key_reg;
        new_ent.expiry  = exp_reg;
        new_ent.action  = act_reg;
        new_ent.payload = pay_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        gen_next   = gen_reg;
        hit_next   = hit_reg;
        left_next  = left_reg;
        full_next  = full_reg;
        rem_next   = rem_reg;
        ctl        = '0;
        head_in    = tail;
        drop_now   = 1'b0;
        strobe      = 1'b0;
        status      = ktt_pkg::ST_OK;
        out_key     = '0;
        out_auto    = 1'b0;
        out_owner   = '0;
        out_action  = '0;
        out_payload = '0;
        removed_count = '0;
        timers_left = 1'b0;
        last        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cnt_next  = '0;
                hit_next  = 1'b0;
                left_next = 1'b0;
                rem_next  = '0;
                if (start)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                ctl.rotate = 1'b1;
                case (kind_reg)
                    ktt_pkg::KIND_ADD:
                    begin
                        // generated keys skip the duplicate check
                        if (match && !key_reg[16])
                            hit_next = 1'b1;
                    end
                    ktt_pkg::KIND_DEL:
                    begin
                        // first match seen is the newest one
                        if (match && !hit_reg)
                        begin
                            hit_next = 1'b1;
                            drop_now = 1'b1;
                        end
                    end
                    ktt_pkg::KIND_EXISTS:
                    begin
                        if (match)
                            hit_next = 1'b1;
                    end
                    ktt_pkg::KIND_DELALL:
                    begin
                        if (tail.valid && tail.owner == own_reg)
                        begin
                            drop_now = 1'b1;
                            rem_next = rem_reg + 6'd1;
                        end
                    end
                    ktt_pkg::KIND_POLL:
                    begin
                        if (tail.valid)
                        begin
                            if (expired)
                            begin
                                drop_now    = 1'b1;
                                strobe      = 1'b1;
                                status      = ktt_pkg::ST_FIRED;
                                out_key     = tail.key[15:0];
                                out_auto    = tail.key[16];
                                out_owner   = tail.owner;
                                out_action  = tail.action;
                                out_payload = tail.payload;
                            end
                            else
                                left_next = 1'b1;
                        end
                    end
                    ktt_pkg::KIND_FLUSH:
                        drop_now = 1'b1;
                    default:
                    begin
                    end
                endcase
                head_in.valid = tail.valid && !drop_now;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(SLOTS - 1))
                    state_next = (kind_reg == ktt_pkg::KIND_ADD) ? S_INS : S_DONE;
            end
            S_INS:
            begin
                // Insert only when the key is new and a cell is free.
                ctl.insert = do_ins;
                full_next  = !hole[SLOTS-1];
                if (do_ins && key_reg[16])
                    gen_next = gen_reg + 16'd1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                strobe     = 1'b1;
                last       = 1'b1;
                state_next = S_IDLE;
                case (kind_reg)
                    ktt_pkg::KIND_ADD:
                    begin
                        if (hit_reg)
                        begin
                            status   = ktt_pkg::ST_DUP;
                            out_key  = key_reg[15:0];
                            out_auto = key_reg[16];
                        end
                        else if (full_reg)
                            status = ktt_pkg::ST_FULL;
                        else
                        begin
                            status   = ktt_pkg::ST_OK;
                            // counter already advanced past the key just used
                            out_key  = key_reg[16] ? gen_reg - 16'd1 : key_reg[15:0];
                            out_auto = key_reg[16];
                        end
                    end
                    ktt_pkg::KIND_DEL, ktt_pkg::KIND_EXISTS:
                        status = hit_reg ? ktt_pkg::ST_OK : ktt_pkg::ST_MISS;
                    ktt_pkg::KIND_DELALL:
                        removed_count = rem_reg;
                    ktt_pkg::KIND_POLL:
                    begin
                        status      = ktt_pkg::ST_POLLEND;
                        timers_left = left_reg;
                    end
                    default:
                        status = ktt_pkg::ST_OK;
                endcase
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            gen_reg   <= '0;
            hit_reg   <= 1'b0;
            left_reg  <= 1'b0;
            full_reg  <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            gen_reg   <= gen_next;
            hit_reg   <= hit_next;
            left_reg  <= left_next;
            full_reg  <= full_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            kind_reg <= kind;
            own_reg  <= owner;
            key_reg  <= {auto_key, timer_key};
            exp_reg  <= (interval == 32'd0) ? 33'd0 : {1'b0, now} + {1'b0, interval};
            act_reg  <= action;
            pay_reg  <= payload;
            now_reg  <= {1'b0, now};
        end
    end
endmodule
